>>> rtl/core/tmpaq_pkg.sv
`default_nettype none

package tmpaq_pkg;

    // Field widths.
    localparam int TEMP_W     = 12;
    localparam int DEPTH_W    = 5;
    localparam int RUN_W      = 5;
    localparam int INTERVAL_W = 12;
    localparam int SECONDS_W  = 32;

    // Window capacity and per-level counter width.
    localparam int WINDOW_MAX  = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int OUT_COUNT_W = 16;

    // Alert bands in tenths of a degree.
    localparam int BAND_NEAR = 20;
    localparam int BAND_FAR  = 50;

    // Consecutive alert samples are counted up to this value.
    localparam logic [RUN_W-1:0] STREAK_MAX = '1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THRESHOLD_LOW  = 3'd0,
        REG_THRESHOLD_HIGH = 3'd1,
        REG_WINDOW_DEPTH   = 3'd2,
        REG_CONFIRM_COUNT  = 3'd3,
        REG_INTERVAL       = 3'd4
    } cfg_reg_t;

    // Alarm levels.
    typedef enum logic [1:0] {
        LVL_NORMAL = 2'd0,
        LVL_NEAR   = 2'd1,
        LVL_FAR    = 2'd2,
        LVL_SEVERE = 2'd3
    } level_t;

    // Window result handed to the output register.
    typedef struct packed {
        logic [RUN_W-1:0] run_length;
        logic             confirmed;
    } window_result_t;

endpackage

`default_nettype wire

>>> rtl/core/tmpaq_grade.sv
`default_nettype none

module tmpaq_grade
    import tmpaq_pkg::*;
(
    input  wire logic signed [TEMP_W-1:0] temperature,
    input  wire logic signed [TEMP_W-1:0] threshold_low,
    input  wire logic signed [TEMP_W-1:0] threshold_high,
    output level_t                        level
);

    logic signed [TEMP_W+1:0] diff_low;
    logic signed [TEMP_W+1:0] diff_high;
    logic signed [TEMP_W+1:0] diff;
    logic                     outside;

    // Distance outside the band, measured from the limit that was crossed.
    always_comb
    begin
        diff_low  = (TEMP_W+2)'(threshold_low) - (TEMP_W+2)'(temperature);
        diff_high = (TEMP_W+2)'(temperature) - (TEMP_W+2)'(threshold_high);
        outside   = 1'b1;
        if (temperature < threshold_low)
        begin
            diff = diff_low;
        end
        else if (temperature > threshold_high)
        begin
            diff = diff_high;
        end
        else
        begin
            diff    = '0;
            outside = 1'b0;
        end
    end

    // Grade the distance against the two bands.
    always_comb
    begin
        if (!outside)
        begin
            level = LVL_NORMAL;
        end
        else if (diff <= (TEMP_W+2)'(BAND_NEAR))
        begin
            level = LVL_NEAR;
        end
        else if (diff <= (TEMP_W+2)'(BAND_FAR))
        begin
            level = LVL_FAR;
        end
        else
        begin
            level = LVL_SEVERE;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tmpaq_window.sv
`default_nettype none

module tmpaq_window
    import tmpaq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire level_t               level,
    input  wire logic [DEPTH_W-1:0]   window_depth,
    input  wire logic [RUN_W-1:0]     confirm_count,
    output window_result_t            result
);

    logic [RUN_W-1:0]   runs_reg [3];
    logic [RUN_W-1:0]   runs_next [3];
    logic [DEPTH_W-1:0] fill_reg;
    logic [DEPTH_W-1:0] fill_next;
    logic [DEPTH_W-1:0] depth_cap;
    logic [DEPTH_W-1:0] fill_inc;
    logic [RUN_W-1:0]   run_inc [3];

    // Window fill grows by one per sample up to the (capped) depth.
    always_comb
    begin
        depth_cap = (window_depth > DEPTH_W'(WINDOW_MAX)) ? DEPTH_W'(WINDOW_MAX)
                                                          : window_depth;
        fill_inc  = fill_reg + 1'b1;
        fill_next = (fill_inc > depth_cap) ? depth_cap : fill_inc;
    end

    // Each level's trailing run grows while the sample is at or above it.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            run_inc[k] = runs_reg[k] + 1'b1;
            if (2'(k + 1) <= level)
            begin
                runs_next[k] = (run_inc[k] > RUN_W'(fill_next)) ? RUN_W'(fill_next)
                                                                 : run_inc[k];
            end
            else
            begin
                runs_next[k] = '0;
            end
        end
    end

    // Run of the current level and its confirmation.
    always_comb
    begin
        case (level)
            LVL_NEAR:   result.run_length = runs_next[0];
            LVL_FAR:    result.run_length = runs_next[1];
            LVL_SEVERE: result.run_length = runs_next[2];
            default:    result.run_length = '0;
        endcase
        result.confirmed = (level != LVL_NORMAL) && (result.run_length >= confirm_count);
    end

    // Window state advances once per sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                runs_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            fill_reg <= fill_next;
            for (int k = 0; k < 3; k++)
            begin
                runs_reg[k] <= runs_next[k];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tmpaq_stats.sv
`default_nettype none

module tmpaq_stats
    import tmpaq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     advance,
    input  wire level_t                   level,
    input  wire logic [RUN_W-1:0]         confirm_count,
    input  wire logic [INTERVAL_W-1:0]    interval_seconds,
    output logic [COUNT_WIDTH-1:0]        count_level1,
    output logic [COUNT_WIDTH-1:0]        count_level2,
    output logic [COUNT_WIDTH-1:0]        count_level3,
    output logic [SECONDS_W-1:0]          alert_seconds
);

    logic [COUNT_WIDTH-1:0] counts_reg [3];
    logic [COUNT_WIDTH-1:0] counts_next [3];
    logic [RUN_W-1:0]       streak_reg;
    logic [RUN_W-1:0]       streak_next;
    logic [SECONDS_W-1:0]   seconds_reg;
    logic [SECONDS_W-1:0]   seconds_next;
    logic [SECONDS_W:0]     seconds_sum;

    // Saturating count for the graded level.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            counts_next[k] = counts_reg[k];
            if ((2'(k + 1) == level) && (counts_reg[k] != '1))
            begin
                counts_next[k] = counts_reg[k] + 1'b1;
            end
        end
    end

    // Alert streak and accumulated confirmed seconds.
    always_comb
    begin
        seconds_sum  = (SECONDS_W+1)'(seconds_reg) + (SECONDS_W+1)'(interval_seconds);
        seconds_next = seconds_reg;
        if (level == LVL_NORMAL)
        begin
            streak_next = '0;
        end
        else
        begin
            streak_next = (streak_reg < STREAK_MAX) ? streak_reg + 1'b1 : streak_reg;
            if (streak_next >= confirm_count)
            begin
                seconds_next = seconds_sum[SECONDS_W] ? '1 : seconds_sum[SECONDS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            streak_reg  <= '0;
            seconds_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                counts_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            streak_reg  <= streak_next;
            seconds_reg <= seconds_next;
            for (int k = 0; k < 3; k++)
            begin
                counts_reg[k] <= counts_next[k];
            end
        end
    end

    // Updated values go to the result register.
    assign count_level1  = counts_next[0];
    assign count_level2  = counts_next[1];
    assign count_level3  = counts_next[2];
    assign alert_seconds = seconds_next;

endmodule

`default_nettype wire

>>> rtl/core/temperature_alarm_qualifier.sv
// Temperature alarm qualifier.
// Input channel: in_valid / in_stall with one temperature word in tenths of a
// degree. Output channel: out_valid / out_stall with the alarm level, the
// confirmation flag, the trailing run length, three per-level sample counts
// and the accumulated confirmed alert seconds.
// A word accepted on the input passes a sample register, then the grading,
// window and statistics logic loads the result register, from which the
// receiver takes it. One word is accepted every cycle while the output is
// taken; throughput is then one word per cycle, set by the single pass
// through the sample and result registers.
// When out_stall is high the result register holds its word; the sample
// register still takes one more word, and in_stall rises only when both
// registers are full.
// The user must write configuration via cfg_we / cfg_index / cfg_data only
// while the block is idle (not enforced); higher indexes are ignored.
// Reset clears both registers' valid flags, the window, the counters and the
// alert seconds, and loads the default thresholds and window settings.
`default_nettype none

module temperature_alarm_qualifier
    import tmpaq_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [TEMP_W-1:0]           cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [TEMP_W-1:0]    temperature,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       level,
    output logic                             confirmed,
    output logic [RUN_W-1:0]                 run_length,
    output logic [OUT_COUNT_W-1:0]           count_level1,
    output logic [OUT_COUNT_W-1:0]           count_level2,
    output logic [OUT_COUNT_W-1:0]           count_level3,
    output logic [SECONDS_W-1:0]             alert_seconds
);

    logic signed [TEMP_W-1:0] threshold_low_reg;
    logic signed [TEMP_W-1:0] threshold_high_reg;
    logic [DEPTH_W-1:0]       window_depth_reg;
    logic [RUN_W-1:0]         confirm_count_reg;
    logic [INTERVAL_W-1:0]    interval_reg;

    logic                     sample_valid_reg;
    logic signed [TEMP_W-1:0] sample_reg;
    logic                     out_valid_reg;
    logic                     advance;
    logic                     in_accept;

    level_t                   sample_level;
    window_result_t           window_res;
    logic [COUNT_WIDTH-1:0]   cnt1;
    logic [COUNT_WIDTH-1:0]   cnt2;
    logic [COUNT_WIDTH-1:0]   cnt3;
    logic [SECONDS_W-1:0]     seconds;

    logic [1:0]               level_reg;
    logic                     confirmed_reg;
    logic [RUN_W-1:0]         run_length_reg;
    logic [OUT_COUNT_W-1:0]   count1_reg;
    logic [OUT_COUNT_W-1:0]   count2_reg;
    logic [OUT_COUNT_W-1:0]   count3_reg;
    logic [SECONDS_W-1:0]     seconds_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_low_reg  <= TEMP_W'(150);
            threshold_high_reg <= TEMP_W'(300);
            window_depth_reg   <= DEPTH_W'(10);
            confirm_count_reg  <= RUN_W'(3);
            interval_reg       <= INTERVAL_W'(5);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD_LOW:  threshold_low_reg  <= cfg_data;
                REG_THRESHOLD_HIGH: threshold_high_reg <= cfg_data;
                REG_WINDOW_DEPTH:   window_depth_reg   <= cfg_data[DEPTH_W-1:0];
                REG_CONFIRM_COUNT:  confirm_count_reg  <= cfg_data[RUN_W-1:0];
                REG_INTERVAL:       interval_reg       <= cfg_data[INTERVAL_W-1:0];
                default:            ;
            endcase
        end
    end

    // Handshake: the sample moves on when the result register is empty or taken.
    assign advance   = sample_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = sample_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // Sample register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            sample_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            sample_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= temperature;
        end
    end

    tmpaq_grade u_grade (
        .temperature    (sample_reg),
        .threshold_low  (threshold_low_reg),
        .threshold_high (threshold_high_reg),
        .level          (sample_level)
    );

    tmpaq_window u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .level         (sample_level),
        .window_depth  (window_depth_reg),
        .confirm_count (confirm_count_reg),
        .result        (window_res)
    );

    tmpaq_stats u_stats (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .level            (sample_level),
        .confirm_count    (confirm_count_reg),
        .interval_seconds (interval_reg),
        .count_level1     (cnt1),
        .count_level2     (cnt2),
        .count_level3     (cnt3),
        .alert_seconds    (seconds)
    );

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            level_reg      <= sample_level;
            confirmed_reg  <= window_res.confirmed;
            run_length_reg <= window_res.run_length;
            count1_reg     <= OUT_COUNT_W'(cnt1);
            count2_reg     <= OUT_COUNT_W'(cnt2);
            count3_reg     <= OUT_COUNT_W'(cnt3);
            seconds_reg    <= seconds;
        end
    end

    assign level         = level_reg;
    assign confirmed     = confirmed_reg;
    assign run_length    = run_length_reg;
    assign count_level1  = count1_reg;
    assign count_level2  = count2_reg;
    assign count_level3  = count3_reg;
    assign alert_seconds = seconds_reg;

endmodule

`default_nettype wire

>>> bench/tb_temperature_alarm_qualifier.sv
`timescale 1ns / 100ps

module tb_temperature_alarm_qualifier;
    import tmpaq_pkg::*;

    localparam int CLK_HALF_NS     = 5;
    localparam int TIMEOUT_NS      = 2_000_000;
    localparam int RANDOM_PHASES   = 14;
    localparam int WORDS_PER_PHASE = 125;
    localparam int HOLD_OFF_AT     = 40;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int PAUSE_AT        = 80;
    localparam int TAIL_CYCLES     = 8;
    localparam int DIRECTED_ROWS   = 36;

    // Grading bands and window limit in the predictor's own terms.
    localparam int NEAR_BAND    = 20;
    localparam int FAR_BAND     = 50;
    localparam int WINDOW_CAP   = 16;
    localparam int STREAK_CAP   = 31;
    localparam int COUNT_CAP    = (1 << 16) - 1;
    localparam longint SECONDS_CAP = 64'hFFFF_FFFF;

    // Register index past the last register; writes to it are ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = '1;

    // One row of the directed table: a register write or a sample word,
    // optionally with the level, confirmation and run length typed in.
    typedef struct packed {
        logic                     is_reg;
        logic [CFG_INDEX_W-1:0]   index;
        logic [TEMP_W-1:0]        data;
        logic signed [TEMP_W-1:0] temp;
        logic                     pinned;
        level_t                   lvl;
        logic                     conf;
        logic [RUN_W-1:0]         run;
    } row_t;

    // One expected result word.
    typedef struct {
        level_t                 lvl;
        logic                   conf;
        logic [RUN_W-1:0]       run;
        logic [OUT_COUNT_W-1:0] near_count;
        logic [OUT_COUNT_W-1:0] far_count;
        logic [OUT_COUNT_W-1:0] severe_count;
        logic [SECONDS_W-1:0]   seconds;
    } alarm_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_INDEX_W-1:0]      cfg_index;
    logic [TEMP_W-1:0]           cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [TEMP_W-1:0]    temperature;
    logic                        out_valid;
    logic                        out_stall;
    logic [1:0]                  level;
    logic                        confirmed;
    logic [RUN_W-1:0]            run_length;
    logic [OUT_COUNT_W-1:0]      count_level1;
    logic [OUT_COUNT_W-1:0]      count_level2;
    logic [OUT_COUNT_W-1:0]      count_level3;
    logic [SECONDS_W-1:0]        alert_seconds;

    // Typed-in expectation that travels with the word being offered.
    logic                        pin_on;
    level_t                      pin_level;
    logic                        pin_conf;
    logic [RUN_W-1:0]            pin_run;

    int                          send_idle_pct;
    int                          stall_pct;
    bit                          hold_off_pending;

    // Mirror of the configuration registers, loaded with their reset values.
    logic signed [TEMP_W-1:0]    limit_low    = 12'sd150;
    logic signed [TEMP_W-1:0]    limit_high   = 12'sd300;
    logic [DEPTH_W-1:0]          window_depth = 5'd10;
    logic [DEPTH_W-1:0]          confirm_need = 5'd3;
    logic [INTERVAL_W-1:0]       sample_secs  = 12'd5;

    // Alarm state tracked by the predictor.
    int                          trailing_run [1:3];
    int                          window_fill;
    int                          alert_streak;
    int                          level_count [1:3];
    longint                      alert_total;

    alarm_t                      expected_alarms [$];
    row_t                        directed_table [DIRECTED_ROWS];

    int                          failures;
    int                          words_sent;
    int                          alarms_checked;
    int                          confirmed_seen;
    int                          backpressure_cycles;
    int                          phases_run;

    temperature_alarm_qualifier DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .temperature   (temperature),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .level         (level),
        .confirmed     (confirmed),
        .run_length    (run_length),
        .count_level1  (count_level1),
        .count_level2  (count_level2),
        .count_level3  (count_level3),
        .alert_seconds (alert_seconds)
    );

    // Grade one sample, advance the window and the statistics, and return
    // the result word the block must produce for it.
    function automatic alarm_t grade_sample(input logic signed [TEMP_W-1:0] sample);
        alarm_t a;
        int     tv;
        int     lo;
        int     hi;
        int     diff;
        int     lvl;
        int     depth;
        int     k;
        tv = sample;
        lo = limit_low;
        hi = limit_high;
        if (tv < lo)
            diff = lo - tv;
        else if (tv > hi)
            diff = tv - hi;
        else
            diff = 0;
        if (diff == 0)
            lvl = 0;
        else if (diff <= NEAR_BAND)
            lvl = 1;
        else if (diff <= FAR_BAND)
            lvl = 2;
        else
            lvl = 3;

        // The window never holds more entries than its effective depth.
        depth = (int'(window_depth) > WINDOW_CAP) ? WINDOW_CAP : int'(window_depth);
        window_fill = (window_fill + 1 > depth) ? depth : window_fill + 1;
        for (k = 1; k <= 3; k++)
        begin
            if (k <= lvl)
            begin
                trailing_run[k] = trailing_run[k] + 1;
                if (trailing_run[k] > window_fill)
                    trailing_run[k] = window_fill;
            end
            else
            begin
                trailing_run[k] = 0;
            end
        end

        a.lvl  = level_t'(lvl);
        a.conf = 1'b0;
        a.run  = '0;
        if (lvl > 0)
        begin
            a.run  = RUN_W'(trailing_run[lvl]);
            a.conf = trailing_run[lvl] >= int'(confirm_need);
            if (level_count[lvl] < COUNT_CAP)
                level_count[lvl]++;
            if (alert_streak < STREAK_CAP)
                alert_streak++;
            if (alert_streak >= int'(confirm_need))
            begin
                alert_total = alert_total + longint'(sample_secs);
                if (alert_total > SECONDS_CAP)
                    alert_total = SECONDS_CAP;
            end
        end
        else
        begin
            alert_streak = 0;
        end
        a.near_count   = OUT_COUNT_W'(level_count[1]);
        a.far_count    = OUT_COUNT_W'(level_count[2]);
        a.severe_count = OUT_COUNT_W'(level_count[3]);
        a.seconds      = SECONDS_W'(alert_total);
        return a;
    endfunction

    // Update the configuration mirror for one register write.
    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] index,
                                           input logic [TEMP_W-1:0] data);
        case (cfg_reg_t'(index))
            REG_THRESHOLD_LOW:  limit_low    = data;
            REG_THRESHOLD_HIGH: limit_high   = data;
            REG_WINDOW_DEPTH:   window_depth = data[DEPTH_W-1:0];
            REG_CONFIRM_COUNT:  confirm_need = data[DEPTH_W-1:0];
            REG_INTERVAL:       sample_secs  = data[INTERVAL_W-1:0];
            default:            ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function automatic row_t sample_row(input int temp);
        row_t r;
        r      = '0;
        r.temp = TEMP_W'(temp);
        return r;
    endfunction

    function automatic row_t pinned_row(input int temp, input level_t lvl, input bit conf,
                                        input int run);
        row_t r;
        r        = sample_row(temp);
        r.pinned = 1'b1;
        r.lvl    = lvl;
        r.conf   = conf;
        r.run    = RUN_W'(run);
        return r;
    endfunction

    function automatic row_t register_row(input logic [CFG_INDEX_W-1:0] index, input int data);
        row_t r;
        r        = '0;
        r.is_reg = 1'b1;
        r.index  = index;
        r.data   = TEMP_W'(data);
        return r;
    endfunction

    // Pick a temperature that should land in the target level for the current
    // thresholds, with some plain noise mixed in.
    function automatic int temperature_for(input int target);
        int lo;
        int hi;
        int gap;
        int t;
        lo = limit_low;
        hi = limit_high;
        if ($urandom_range(99) < 12 || (target == 0 && lo > hi))
            return int'(TEMP_W'($urandom)) - ((1 << TEMP_W) / 2);
        if (target == 0)
        begin
            t = lo + int'($urandom_range(hi - lo));
        end
        else
        begin
            case (target)
                1:       gap = int'($urandom_range(1, NEAR_BAND));
                2:       gap = int'($urandom_range(NEAR_BAND + 1, FAR_BAND));
                default: gap = ($urandom_range(2) == 0) ? int'($urandom_range(51, 1500))
                                                        : int'($urandom_range(51, 60));
            endcase
            t = ($urandom_range(1) == 1) ? hi + gap : lo - gap;
        end
        if (t > 2047)
            t = 2047;
        if (t < -2048)
            t = -2048;
        return t;
    endfunction

    // Offer one word, idling first at the current rate, and return at the
    // edge that accepts it.
    task automatic send_sample(input row_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid    <= 1'b0;
            temperature <= TEMP_W'($urandom);
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        temperature <= r.temp;
        pin_on      <= r.pinned;
        pin_level   <= r.lvl;
        pin_conf    <= r.conf;
        pin_run     <= r.run;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop offering and wait until every expected result has arrived.
    // Returns at a falling edge.
    task automatic wait_for_alarms();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_alarms.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index, input int data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= TEMP_W'(data);
        @(posedge clk);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial
    begin : receiver
        int held;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Track register writes and accepted words, and check every result word.
    always @(posedge clk)
    begin : scoreboard
        alarm_t want;
        alarm_t fresh;
        if (rst_n)
        begin
            if (in_valid && in_stall)
                backpressure_cycles++;
            if (out_valid && !out_stall)
            begin
                if (expected_alarms.size() == 0)
                begin
                    $error("result word arrived with none expected");
                    failures++;
                end
                else
                begin
                    want = expected_alarms.pop_front();
                    check_field("level", want.lvl, level);
                    check_field("confirmed", want.conf, confirmed);
                    check_field("run_length", want.run, run_length);
                    check_field("count_level1", want.near_count, count_level1);
                    check_field("count_level2", want.far_count, count_level2);
                    check_field("count_level3", want.severe_count, count_level3);
                    check_field("alert_seconds", want.seconds, alert_seconds);
                    alarms_checked++;
                    if (confirmed === 1'b1)
                        confirmed_seen++;
                end
            end
            if (cfg_we)
                apply_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                fresh = grade_sample(temperature);
                if (pin_on)
                begin
                    fresh.lvl  = pin_level;
                    fresh.conf = pin_conf;
                    fresh.run  = pin_run;
                end
                expected_alarms.push_back(fresh);
                words_sent++;
            end
        end
    end

    // Stimulus: directed table first, then random phases.
    initial
    begin : stimulus
        row_t row;
        bit   writing;
        int   p;
        int   n;
        int   target;
        int   streak_left;
        int   lo;
        int   hi;
        int   swap;
        int   depth;
        int   need;
        int   secs;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_THRESHOLD_LOW;
        cfg_data         = '0;
        in_valid         = 1'b0;
        temperature      = '0;
        pin_on           = 1'b0;
        pin_level        = LVL_NORMAL;
        pin_conf         = 1'b0;
        pin_run          = '0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        hold_off_pending = 1'b0;
        trailing_run     = '{0, 0, 0};
        level_count      = '{0, 0, 0};
        window_fill      = 0;
        alert_streak     = 0;
        alert_total      = 0;
        failures         = 0;
        words_sent       = 0;
        alarms_checked   = 0;
        confirmed_seen   = 0;
        backpressure_cycles = 0;
        phases_run       = 0;

        // Reset thresholds are 150 and 300, depth 10, confirm count 3.
        directed_table = '{
            pinned_row(200, LVL_NORMAL, 0, 0),
            pinned_row(150, LVL_NORMAL, 0, 0),
            pinned_row(300, LVL_NORMAL, 0, 0),
            pinned_row(301, LVL_NEAR, 0, 1),
            pinned_row(320, LVL_NEAR, 0, 2),
            pinned_row(321, LVL_FAR, 0, 1),
            pinned_row(350, LVL_FAR, 0, 2),
            pinned_row(351, LVL_SEVERE, 0, 1),
            pinned_row(2047, LVL_SEVERE, 0, 2),
            pinned_row(2047, LVL_SEVERE, 1, 3),
            sample_row(129),
            sample_row(130),
            sample_row(100),
            sample_row(99),
            pinned_row(-2048, LVL_SEVERE, 0, 2),
            pinned_row(200, LVL_NORMAL, 0, 0),
            // An empty window keeps every run at zero.
            register_row(REG_WINDOW_DEPTH, 0),
            pinned_row(0, LVL_SEVERE, 0, 0),
            // With no confirm count every alert is confirmed.
            register_row(REG_CONFIRM_COUNT, 0),
            pinned_row(0, LVL_SEVERE, 1, 0),
            pinned_row(200, LVL_NORMAL, 0, 0),
            // Depth above the window size acts as the full window.
            register_row(REG_WINDOW_DEPTH, 31),
            pinned_row(-1000, LVL_SEVERE, 1, 1),
            pinned_row(1500, LVL_SEVERE, 1, 2),
            register_row(REG_CONFIRM_COUNT, 31),
            pinned_row(1500, LVL_SEVERE, 0, 3),
            // Lowering the depth trims the window on the next sample.
            register_row(REG_WINDOW_DEPTH, 2),
            pinned_row(1500, LVL_SEVERE, 0, 2),
            register_row(REG_CONFIRM_COUNT, 2),
            pinned_row(1500, LVL_SEVERE, 1, 2),
            register_row(REG_UNUSED, 4095),
            register_row(REG_THRESHOLD_LOW, -2048),
            register_row(REG_THRESHOLD_HIGH, 2047),
            register_row(REG_INTERVAL, 4095),
            pinned_row(-2048, LVL_NORMAL, 0, 0),
            pinned_row(2047, LVL_NORMAL, 0, 0)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. A run of register writes starts once the block is idle.
        writing = 1'b0;
        foreach (directed_table[i])
        begin
            row = directed_table[i];
            if (row.is_reg)
            begin
                if (!writing)
                begin
                    wait_for_alarms();
                    @(posedge clk);
                    writing = 1'b1;
                end
                write_register(row.index, int'(row.data));
            end
            else
            begin
                if (writing)
                begin
                    cfg_we  <= 1'b0;
                    writing = 1'b0;
                end
                send_sample(row);
            end
        end

        // Random phases, each with fresh settings and its own idling pattern.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_for_alarms();
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 77; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 77; end
                default: begin send_idle_pct = 36; stall_pct = 36; end
            endcase
            @(posedge clk);

            case (p)
                0:       begin lo = -1000; hi = 1500;  end
                1:       begin lo = 1500;  hi = 1500;  end
                2:       begin lo = 300;   hi = 150;   end
                3:       begin lo = -2048; hi = -1000; end
                4:       begin lo = 1000;  hi = 2047;  end
                default:
                begin
                    lo = int'($urandom_range(2500)) - 1000;
                    hi = lo + int'($urandom_range(400));
                    if (hi > 2047)
                        hi = 2047;
                    if ($urandom_range(9) == 0)
                    begin
                        swap = lo;
                        lo   = hi;
                        hi   = swap;
                    end
                end
            endcase
            case (p)
                0:       begin depth = 1;  need = 1;  secs = 1;    end
                1:       begin depth = 16; need = 16; secs = 3600; end
                2:       begin depth = 0;  need = 0;  secs = 4095; end
                3:       begin depth = 31; need = 31; secs = 0;    end
                default:
                begin
                    depth = ($urandom_range(4) == 0) ? int'($urandom_range(31))
                                                     : int'($urandom_range(1, 16));
                    need  = ($urandom_range(4) == 0) ? int'($urandom_range(31))
                                                     : int'($urandom_range(1, 16));
                    secs  = int'($urandom_range(1, 3600));
                end
            endcase
            // Bits above the five-bit registers carry junk half of the time.
            if ($urandom_range(1) == 1)
            begin
                depth = depth | (int'($urandom_range(127)) << DEPTH_W);
                need  = need | (int'($urandom_range(127)) << DEPTH_W);
            end
            write_register(REG_THRESHOLD_LOW, lo);
            write_register(REG_THRESHOLD_HIGH, hi);
            write_register(REG_WINDOW_DEPTH, depth);
            write_register(REG_CONFIRM_COUNT, need);
            write_register(REG_INTERVAL, secs);
            cfg_we <= 1'b0;
            phases_run++;

            // Streaks of one target level so that runs build up and confirm.
            streak_left = 0;
            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (streak_left == 0)
                begin
                    target      = int'($urandom_range(3));
                    streak_left = int'($urandom_range(1, 14));
                end
                streak_left--;
                if (p % 4 == 0 && n == HOLD_OFF_AT)
                begin
                    // Receiver holds off while words keep coming, filling the block.
                    in_valid <= 1'b0;
                    @(negedge clk);
                    hold_off_pending = 1'b1;
                    @(posedge clk);
                end
                if (p % 4 == 1 && n == PAUSE_AT)
                begin
                    wait_for_alarms();
                    @(posedge clk);
                end
                send_sample(sample_row(temperature_for(target)));
            end
        end

        wait_for_alarms();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d sample words (directed table plus %0d random setting phases),",
                 words_sent, phases_run);
        $display("checked %0d result words, %0d confirmed, input held off on %0d cycles.",
                 alarms_checked, confirmed_seen, backpressure_cycles);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
